// ----- src/dnpc_pkg.sv -----
`default_nettype none
package dnpc_pkg;

  // Line store depth, i.e. the widest frame the block can take.
  localparam int MAX_WIDTH  = 1024;
  localparam int HEIGHT_CAP = 1024;

  localparam int PIX_W   = 8;
  localparam int THR_W   = 8;
  localparam int DIM_W   = 11;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = 10;
  localparam int CMP_W   = ((DIM_W > COL_W) ? DIM_W : COL_W) + 2;
  localparam int CNT_W   = 20;
  localparam int TOT_W   = 22;
  localparam int FRAC_W  = 17;
  localparam int REM_W   = TOT_W + 1;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

  localparam logic [THR_W-1:0] THRESHOLD_RST = 8'd150;
  localparam logic [DIM_W-1:0] WIDTH_RST     = 11'd1024;
  localparam logic [DIM_W-1:0] HEIGHT_RST    = 11'd1024;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One classified pixel
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             dark;
    logic             cnt_en;     // dark and at least two rows in
    logic             dl_ok;
    logic             dn_ok;
    logic             dr_ok;
    logic             frame_end;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] dl;
    logic [CNT_W-1:0] dn;
    logic [CNT_W-1:0] dr;
  } counts_t;

endpackage
`default_nettype wire

// ----- src/dnpc_if.sv -----
`default_nettype none
interface dnpc_in_if;
  logic                      valid;
  logic                      ready;
  logic [dnpc_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface dnpc_out_if;
  logic                       valid;
  logic                       ready;
  logic [dnpc_pkg::FRAC_W-1:0] frac_down_left;
  logic [dnpc_pkg::FRAC_W-1:0] frac_down;
  logic [dnpc_pkg::FRAC_W-1:0] frac_down_right;
  logic [dnpc_pkg::TOT_W-1:0]  total_pairs;

  modport source (output valid, output frac_down_left, output frac_down,
                  output frac_down_right, output total_pairs, input ready);
  modport sink   (input valid, input frac_down_left, input frac_down,
                  input frac_down_right, input total_pairs, output ready);
endinterface
`default_nettype wire

// ----- src/dnpc_front.sv -----
`default_nettype none
module dnpc_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  dnpc_in_if.sink                              in_ch,
  input  wire logic                            cfg_we,
  input  wire logic [dnpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dnpc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            line_clear,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output dnpc_pkg::item_t                      q_item
);
  import dnpc_pkg::*;

  logic [THR_W-1:0] thr_r;
  logic [DIM_W-1:0] width_r, height_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic [CMP_W-1:0] wr, hr, w_eff, h_eff, cc, rr;
  logic             last_col, last_row, accept;

  assign in_ch.ready = !line_clear && !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_push      = accept;

  always_comb begin
    wr = CMP_W'(width_r);
    hr = CMP_W'(height_r);
    if (wr < CMP_W'(3))              w_eff = CMP_W'(3);
    else if (wr > CMP_W'(MAX_WIDTH)) w_eff = CMP_W'(MAX_WIDTH);
    else                             w_eff = wr;
    if (hr < CMP_W'(3))               h_eff = CMP_W'(3);
    else if (hr > CMP_W'(HEIGHT_CAP)) h_eff = CMP_W'(HEIGHT_CAP);
    else                              h_eff = hr;
    cc = CMP_W'(col_r);
    rr = CMP_W'(row_r);
    last_col = cc >= w_eff - CMP_W'(1);
    last_row = rr >= h_eff - CMP_W'(1);

    q_item.col       = col_r;
    q_item.dark      = in_ch.pixel < thr_r;
    q_item.cnt_en    = q_item.dark && (row_r >= ROW_W'(2));
    q_item.dl_ok     = (cc + CMP_W'(2)) < w_eff;
    q_item.dn_ok     = (cc != '0) && ((cc + CMP_W'(1)) < w_eff);
    q_item.dr_ok     = (cc >= CMP_W'(2)) && (cc < w_eff);
    q_item.frame_end = last_col && last_row;

    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THRESHOLD_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_THRESHOLD: thr_r    <= cfg_data[THR_W-1:0];
          CFG_WIDTH:     width_r  <= cfg_data[DIM_W-1:0];
          CFG_HEIGHT:    height_r <= cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/dnpc_fifo.sv -----
`default_nettype none
module dnpc_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire dnpc_pkg::item_t  push_item,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output dnpc_pkg::item_t       head_item
);
  import dnpc_pkg::*;

  item_t            entry_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     count_r, count_nxt;

  assign full       = count_r == (QAW+1)'(QDEPTH);
  assign head_valid = count_r != '0;
  assign head_item  = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop)      count_nxt = count_r + (QAW+1)'(1);
    else if (!push && pop) count_nxt = count_r - (QAW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QAW'(1);
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/dnpc_back.sv -----
`default_nettype none
module dnpc_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire dnpc_pkg::item_t q_item,
  output logic                 q_pop,
  output logic                 line_clear,
  input  wire logic            div_busy,
  output logic                 div_start,
  output dnpc_pkg::counts_t    div_counts
);
  import dnpc_pkg::*;

  logic             line_r [MAX_WIDTH];
  logic             clr_busy_r;
  logic [COL_W-1:0] clr_addr_r;

  item_t            ex_r;
  logic             ex_valid_r;
  logic             center_r, right_r, prev_center_r;
  logic [COL_W-1:0] right_addr;
  logic             retire, load;
  logic             inc_dl, inc_dn, inc_dr;
  counts_t          cnt_r, cnt_bumped;

  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c, logic inc);
    return (inc && c != COUNT_MAX) ? c + CNT_W'(1) : c;
  endfunction

  assign line_clear = clr_busy_r;
  // a frame end waits here until the divider is free
  assign retire     = ex_valid_r && !(ex_r.frame_end && div_busy);
  assign load       = q_valid && !clr_busy_r && (!ex_valid_r || retire);
  assign q_pop      = load;
  assign right_addr = q_item.col + COL_W'(1);

  // above-left comes from the previous beat's above value
  assign inc_dl = ex_r.cnt_en && ex_r.dl_ok && right_r;
  assign inc_dn = ex_r.cnt_en && ex_r.dn_ok && center_r;
  assign inc_dr = ex_r.cnt_en && ex_r.dr_ok && prev_center_r;

  always_comb begin
    cnt_bumped.dl = bump(cnt_r.dl, inc_dl);
    cnt_bumped.dn = bump(cnt_r.dn, inc_dn);
    cnt_bumped.dr = bump(cnt_r.dr, inc_dr);
  end

  assign div_start  = retire && ex_r.frame_end;
  assign div_counts = cnt_bumped;

  // Next beat reads col+1/col+2 (or 0/1 after a row end), never the
  // entry written this cycle, so no bypass is needed.
  always_ff @(posedge clk) begin
    if (clr_busy_r)  line_r[clr_addr_r] <= 1'b0;
    else if (retire) line_r[ex_r.col]   <= ex_r.dark;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      center_r <= line_r[q_item.col];
      right_r  <= line_r[right_addr];
      ex_r     <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r    <= 1'b1;
      clr_addr_r    <= '0;
      ex_valid_r    <= 1'b0;
      prev_center_r <= 1'b0;
      cnt_r         <= '0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + COL_W'(1);
        if (clr_addr_r == COL_W'(MAX_WIDTH - 1)) clr_busy_r <= 1'b0;
      end
      if (load)        ex_valid_r <= 1'b1;
      else if (retire) ex_valid_r <= 1'b0;
      if (retire) begin
        prev_center_r <= center_r;
        cnt_r         <= ex_r.frame_end ? '0 : cnt_bumped;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/dnpc_div.sv -----
`default_nettype none
module dnpc_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire dnpc_pkg::counts_t counts,
  output logic                   busy,
  dnpc_out_if.source             out_ch
);
  import dnpc_pkg::*;

  localparam int STEP_W = $clog2(FRAC_W);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SUM  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } div_state_t;

  div_state_t state_r, state_nxt;
  logic [2:0][CNT_W-1:0]  num_r, num_nxt;
  logic [2:0][REM_W-1:0]  rem_r, rem_nxt;
  logic [2:0][FRAC_W-1:0] q_r, q_nxt;
  logic [2:0][REM_W-1:0]  rem_sub;
  logic [2:0]             ge;
  logic [TOT_W-1:0]       total_r, total_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;

  assign busy                   = state_r != S_IDLE;
  assign out_ch.valid           = state_r == S_DONE;
  assign out_ch.frac_down_left  = q_r[0];
  assign out_ch.frac_down       = q_r[1];
  assign out_ch.frac_down_right = q_r[2];
  assign out_ch.total_pairs     = total_r;

  // Restoring division, one quotient bit per lane a cycle. Each count is at
  // most the total, so the remainder starts at the count itself.
  always_comb begin
    state_nxt = state_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    total_nxt = total_r;
    step_nxt  = step_r;
    for (int i = 0; i < 3; i++) begin
      ge[i]      = rem_r[i] >= REM_W'(total_r);
      rem_sub[i] = ge[i] ? rem_r[i] - REM_W'(total_r) : rem_r[i];
    end
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          num_nxt   = {counts.dr, counts.dn, counts.dl};
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        total_nxt = TOT_W'(num_r[0]) + TOT_W'(num_r[1]) + TOT_W'(num_r[2]);
        for (int i = 0; i < 3; i++) begin
          rem_nxt[i] = REM_W'(num_r[i]);
          q_nxt[i]   = '0;
        end
        step_nxt  = STEP_W'(FRAC_W - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        for (int i = 0; i < 3; i++) begin
          rem_nxt[i] = {rem_sub[i][REM_W-2:0], 1'b0};
          q_nxt[i]   = {q_r[i][FRAC_W-2:0], ge[i]};
        end
        if (step_r == '0) begin
          if (total_r == '0) q_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      S_DONE: begin
        if (out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    num_r   <= num_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    total_r <= total_nxt;
    step_r  <= step_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

// ----- src/diagonal_neighbor_pair_counter_top.sv -----
// Counts dark diagonal/vertical neighbor pairs in a raster-order grayscale
// frame and reports, at the frame's last pixel, the below-left, below and
// below-right counts as Q1.16 shares of their total (truncated, zero when
// the total is zero) together with the total. Pixels are taken one per
// cycle while the queue has room and no line-store clear runs; the line
// store is a single-bit RAM written once per pixel, and that write port
// is what sets the one-pixel-per-cycle figure. After reset the line store
// is cleared, during which in_ch.ready is low; configuration writes are
// taken at any time. A frame's result becomes valid after its last pixel
// passes the queue and line-store read, a sum state and 17 divide steps
// shared by the three shares. A frame end stalls the pixel path only while
// the previous frame's result is still being divided or awaits out_ch.ready.
`default_nettype none
module diagonal_neighbor_pair_counter_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  dnpc_in_if.sink                              in_ch,
  dnpc_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [dnpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dnpc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dnpc_pkg::*;

  item_t   push_item, head_item;
  counts_t div_counts;
  logic    q_push, q_full, q_pop, head_valid;
  logic    line_clear, div_busy, div_start;

  dnpc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .line_clear (line_clear),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (push_item)
  );

  dnpc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  dnpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (head_valid),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .line_clear (line_clear),
    .div_busy   (div_busy),
    .div_start  (div_start),
    .div_counts (div_counts)
  );

  dnpc_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .counts (div_counts),
    .busy   (div_busy),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

// ----- src/dnpc_checker.sv -----
`default_nettype none
module dnpc_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [dnpc_pkg::FRAC_W-1:0]  frac_dl,
  input wire logic [dnpc_pkg::FRAC_W-1:0]  frac_dn,
  input wire logic [dnpc_pkg::FRAC_W-1:0]  frac_dr,
  input wire logic [dnpc_pkg::TOT_W-1:0]   total
);
  import dnpc_pkg::*;

  localparam logic [FRAC_W+1:0] ONE = (FRAC_W+2)'(65536);

  logic [FRAC_W+1:0] frac_sum;
  assign frac_sum = (FRAC_W+2)'(frac_dl) + (FRAC_W+2)'(frac_dn) + (FRAC_W+2)'(frac_dr);

  // line store clear holds off pixels right after reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ready)
    else $error("pixel beat possible before line store clear");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(frac_dl) && $stable(frac_dn)
                               && $stable(frac_dr) && $stable(total))
    else $error("result beat changed while stalled");

  a_zero_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && total == '0 |-> frac_sum == '0)
    else $error("nonzero share with zero total");

  // three truncated shares lose less than one LSB each
  a_share_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && total != '0 |-> frac_sum <= ONE && frac_sum >= ONE - (FRAC_W+2)'(2))
    else $error("shares do not add up to one");

endmodule

bind diagonal_neighbor_pair_counter_top dnpc_checker u_dnpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .frac_dl   (out_ch.frac_down_left),
  .frac_dn   (out_ch.frac_down),
  .frac_dr   (out_ch.frac_down_right),
  .total     (out_ch.total_pairs)
);
`default_nettype wire

// ----- sim/diagonal_neighbor_pair_counter_top_tb.sv -----
`timescale 1ns / 1ps

class pair_share_scoreboard;
  typedef struct packed {
    logic [dnpc_pkg::FRAC_W-1:0] dl;
    logic [dnpc_pkg::FRAC_W-1:0] dn;
    logic [dnpc_pkg::FRAC_W-1:0] dr;
    logic [dnpc_pkg::TOT_W-1:0]  total;
  } shares_t;

  bit [dnpc_pkg::THR_W-1:0] thr;
  bit [dnpc_pkg::DIM_W-1:0] width_reg;
  bit [dnpc_pkg::DIM_W-1:0] height_reg;
  bit                       dark_row [dnpc_pkg::MAX_WIDTH];
  bit                       above_left;
  bit                       above;
  int unsigned              col;
  int unsigned              row;
  bit [dnpc_pkg::CNT_W-1:0] n_dl;
  bit [dnpc_pkg::CNT_W-1:0] n_dn;
  bit [dnpc_pkg::CNT_W-1:0] n_dr;
  shares_t                  pending [$];
  int unsigned              errors;
  int unsigned              pixels;
  int unsigned              results;

  function new();
    thr        = dnpc_pkg::THRESHOLD_RST;
    width_reg  = dnpc_pkg::WIDTH_RST;
    height_reg = dnpc_pkg::HEIGHT_RST;
  endfunction

  function int unsigned clamp_dim(bit [dnpc_pkg::DIM_W-1:0] v);
    if (v < 3) return 3;
    if (v > dnpc_pkg::MAX_WIDTH) return dnpc_pkg::MAX_WIDTH;
    return v;
  endfunction

  function bit [dnpc_pkg::CNT_W-1:0] bump(bit [dnpc_pkg::CNT_W-1:0] c);
    return (c == dnpc_pkg::COUNT_MAX) ? c : c + 1'b1;
  endfunction

  function bit [dnpc_pkg::FRAC_W-1:0] share_of(bit [dnpc_pkg::CNT_W-1:0] c,
                                               bit [31:0] total);
    bit [63:0] q;
    if (total == 0) return '0;
    q = ({44'd0, c} << 16) / total;
    return q[dnpc_pkg::FRAC_W-1:0];
  endfunction

  function void write_reg(bit [dnpc_pkg::CFG_IDX_W-1:0] idx,
                          bit [dnpc_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      dnpc_pkg::CFG_THRESHOLD: thr = val[dnpc_pkg::THR_W-1:0];
      dnpc_pkg::CFG_WIDTH:     width_reg = val;
      dnpc_pkg::CFG_HEIGHT:    height_reg = val;
      default: ;
    endcase
  endfunction

  function void note_pixel(bit [dnpc_pkg::PIX_W-1:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    bit          d;
    bit          above_right;
    bit [31:0]   total;
    shares_t     s;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    c = col % dnpc_pkg::MAX_WIDTH;
    r = row;
    d = px < thr;
    pixels++;
    above_left  = above;
    above       = dark_row[c];
    above_right = (c + 1 < dnpc_pkg::MAX_WIDTH) ? dark_row[c + 1] : 1'b0;
    if (d && r >= 2) begin
      if (c + 2 < w && above_right) n_dl = bump(n_dl);
      if (c >= 1 && c + 1 < w && above) n_dn = bump(n_dn);
      if (c >= 2 && c < w && above_left) n_dr = bump(n_dr);
    end
    dark_row[c] = d;
    if (c >= w - 1) begin
      col = 0;
      // a shrunk height ends the frame at the current row
      if (r >= h - 1) begin
        total   = n_dl + n_dn + n_dr;
        s.dl    = share_of(n_dl, total);
        s.dn    = share_of(n_dn, total);
        s.dr    = share_of(n_dr, total);
        s.total = total[dnpc_pkg::TOT_W-1:0];
        pending.push_back(s);
        n_dl = '0;
        n_dn = '0;
        n_dr = '0;
        row  = 0;
      end else begin
        row = (r + 1) % 1024;
      end
    end else begin
      col = c + 1;
    end
  endfunction

  function void compare(string field, bit [31:0] want, bit [31:0] got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endfunction

  function void check_result(shares_t got);
    shares_t want;
    if (pending.size() == 0) begin
      $error("frame result with no frame end pending (total_pairs %0d)", got.total);
      errors++;
      return;
    end
    want = pending.pop_front();
    results++;
    compare("frac_down_left", want.dl, got.dl);
    compare("frac_down", want.dn, got.dn);
    compare("frac_down_right", want.dr, got.dr);
    compare("total_pairs", want.total, got.total);
  endfunction
endclass

module diagonal_neighbor_pair_counter_top_tb;
  import dnpc_pkg::*;

  localparam int TIMEOUT_CYCLES = 20000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_ITEMS   = 1550;
  localparam int BIG_ITEMS      = 400;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned quiet_cycles;
  int unsigned settings;

  pair_share_scoreboard sb = new();

  dnpc_in_if  in_ch ();
  dnpc_out_if out_ch ();

  diagonal_neighbor_pair_counter_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // beat monitor and watchdog
  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) sb.note_pixel(in_ch.pixel);
    if (out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.frac_down_left, out_ch.frac_down,
                       out_ch.frac_down_right, out_ch.total_pairs});
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= TIMEOUT_CYCLES) begin
      $display("diagonal_neighbor_pair_counter_top test failed");
      $finish;
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] px);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pixel <= px;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic logic [PIX_W-1:0] random_pixel(int unsigned dark_pct);
    if ($urandom_range(3) == 0 || sb.thr == 0) return PIX_W'($urandom);
    if ($urandom_range(99) < dark_pct) return PIX_W'($urandom_range(sb.thr - 1, 0));
    return PIX_W'($urandom_range(255, sb.thr));
  endfunction

  task automatic send_random(input int unsigned n);
    int unsigned dark_pct;
    case ($urandom_range(3))
      0:       dark_pct = 0;
      1:       dark_pct = 100;
      default: dark_pct = $urandom_range(100);
    endcase
    repeat (n) send_pixel(random_pixel(dark_pct));
  endtask

  // wait out every pending frame result and the pipeline behind it
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [THR_W-1:0] thr, input logic [DIM_W-1:0] w,
                           input logic [DIM_W-1:0] h);
    logic [CFG_IDX_W-1:0]  idx [3];
    logic [CFG_DATA_W-1:0] val [3];
    idx[0] = CFG_THRESHOLD;
    idx[1] = CFG_WIDTH;
    idx[2] = CFG_HEIGHT;
    // bits above the threshold field are don't-care
    val[0] = {3'($urandom_range(7)), thr};
    val[1] = w;
    val[2] = h;
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  initial begin
    int unsigned    fed;
    int unsigned    seg;
    int unsigned    n;
    int unsigned    frames;
    bit             big;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [THR_W-1:0] thr;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_THRESHOLD;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.pixel    = '0;
    out_ch.ready   = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    quiet_cycles   = 0;
    settings       = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // smallest frame: all dark gives one pair of each kind, all light gives zero total
    configure(8'd128, 11'd3, 11'd3);
    for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'd127 : 8'd0);
    for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'd255 : 8'd128);

    fed = 0;
    seg = 0;
    while (fed < RANDOM_ITEMS) begin
      case ((seg / 4) % 4)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 64; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 64; end
        default: begin src_idle_pct = 35; sink_stall_pct = 35; end
      endcase
      drain();
      big = 1'b1;
      if (seg == 3) begin
        w = 11'd1024;
        h = 11'd3;
      end else if (seg == 9) begin
        w = 11'd3;
        h = 11'd2047;
      end else begin
        big = 1'b0;
        w = ($urandom_range(9) == 0) ? DIM_W'($urandom_range(2)) : DIM_W'($urandom_range(8, 3));
        h = ($urandom_range(9) == 0) ? DIM_W'($urandom_range(2)) : DIM_W'($urandom_range(6, 3));
      end
      case ($urandom_range(4))
        0:       thr = 8'd0;
        1:       thr = 8'd255;
        2:       thr = THRESHOLD_RST;
        default: thr = THR_W'($urandom);
      endcase
      configure(thr, w, h);
      n = sb.clamp_dim(w) * sb.clamp_dim(h);
      if (big) begin
        // part of one wide or tall frame; the next resize cuts it short
        send_random(BIG_ITEMS);
        fed += BIG_ITEMS;
      end else begin
        frames = $urandom_range(3, 1);
        repeat (frames) send_random(n);
        fed += frames * n;
        // leave a frame open so the next size change lands mid-frame
        if ($urandom_range(4) == 0) begin
          frames = $urandom_range(n - 1, 1);
          send_random(frames);
          fed += frames;
        end
      end
      seg++;
    end

    drain();
    $display("Checked %0d frame results from %0d pixels over %0d register settings",
             sb.results, sb.pixels, settings);
    $display("Frames 3 to 8 on a side, partial 1024-wide and 1024-tall frames, thresholds 0 to 255, mid-frame resizes");
    if (sb.errors == 0)
      $display("diagonal_neighbor_pair_counter_top test passed");
    else
      $display("diagonal_neighbor_pair_counter_top test failed");
    $finish;
  end
endmodule
